FILE: hdl/clsd_pkg.sv
// clsd_pkg: shared constants and types for the 3x3 binary closing stream.
// No dependencies; used by clsd_front, clsd_back and the top level.
package clsd_pkg;

    // Structuring element edge and the per-column history depth it needs
    localparam int WIN    = 3;
    localparam int HIST_W = WIN - 1;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

    localparam logic [7:0]             THRESHOLD_RST = 8'd128;
    localparam logic [CFG_DATA_W-1:0]  FRAME_DIM_RST = 11'd1024;

    localparam logic [7:0] PIX_SET = 8'd255;
    localparam logic [7:0] PIX_CLR = 8'd0;

    // Front to back queue depth
    localparam int QUEUE_DEPTH = 4;

    // One classified request, front to back
    typedef struct packed {
        logic              is_pixel;  // 0: drain request
        logic              emit;      // produces a result
        logic              keep;      // result position is inside the valid area
        logic              last;      // result is the frame's final pixel
        logic              bin;       // thresholded input pixel
        logic [HIST_W-1:0] x_mask;    // bit i: column > i
        logic [HIST_W-1:0] y_mask;    // bit i: row > i
    } cmd_t;

endpackage

FILE: hdl/clsd_ram.sv
// clsd_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module clsd_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/clsd_fifo.sv
// clsd_fifo: small flop-based FIFO between the front and back parts.
// No dependencies.
module clsd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == NW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + NW'(1);
        end else if (!do_push && do_pop) begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hdl/clsd_front.sv
// clsd_front: config registers, raster position tracking and request classification.
// Depends on clsd_pkg.
module clsd_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [clsd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [clsd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  logic [7:0]                          s_level,
    output logic                                q_push,
    output clsd_pkg::cmd_t                      q_cmd,
    output logic [$clog2(MAX_WIDTH)-1:0]        q_col,
    input  logic                                q_full
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int CNTW = $clog2(clsd_pkg::HIST_W * (MAX_WIDTH + 1) + 1);
    localparam int HIST_W = clsd_pkg::HIST_W;

    logic [7:0]                      thr_reg;
    logic [clsd_pkg::CFG_DATA_W-1:0] fw_reg, fh_reg;
    logic [CW-1:0]   in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [RW-1:0]   in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            frame_rcv_reg, frame_rcv_next;

    logic [WW-1:0]   eff_w;
    logic [HW-1:0]   eff_h;
    logic [CNTW-1:0] lag, cnt_cur;
    logic            accept, is_pix, px_emit, do_emit, restart;
    logic            in_col_wrap, in_row_wrap;
    logic [CW-1:0]   oc_base;
    logic [RW-1:0]   or_base;
    logic            out_last, out_eol, keep;
    logic [HIST_W-1:0] x_mask, y_mask;

    // Clamp frame size to 1..MAX
    always_comb begin
        if (fw_reg == '0) begin
            eff_w = WW'(1);
        end else if (int'(fw_reg) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(fw_reg);
        end
        if (fh_reg == '0) begin
            eff_h = HW'(1);
        end else if (int'(fh_reg) > MAX_HEIGHT) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(fh_reg);
        end
    end

    assign s_ready = !q_full;
    assign accept  = s_valid && !q_full;
    assign is_pix  = !s_kind;
    assign restart = cfg_wr_en && (cfg_index == clsd_pkg::CFG_FRAME_WIDTH
                                   || cfg_index == clsd_pkg::CFG_FRAME_HEIGHT);

    // Pipeline fill: results start once HIST_W*(w+1) pixels are in
    assign lag     = CNTW'(HIST_W) * (CNTW'(eff_w) + CNTW'(1));
    assign cnt_cur = (in_col_reg == '0 && in_row_reg == '0) ? '0 : cnt_reg;
    assign px_emit = (cnt_cur >= lag);

    assign in_col_wrap = (WW'(in_col_reg) + WW'(1)) >= eff_w;
    assign in_row_wrap = (HW'(in_row_reg) + HW'(1)) >= eff_h;

    // A pixel arriving with results still pending drops them
    assign oc_base = (frame_rcv_reg && is_pix) ? '0 : out_col_reg;
    assign or_base = (frame_rcv_reg && is_pix) ? '0 : out_row_reg;

    assign out_eol  = (WW'(oc_base) + WW'(1)) >= eff_w;
    assign out_last = ((WW'(oc_base) + WW'(1)) == eff_w)
                   && ((HW'(or_base) + HW'(1)) == eff_h);
    assign keep = ((WW+1)'(oc_base) + (WW+1)'(HIST_W) < (WW+1)'(eff_w))
               && ((HW+1)'(or_base) + (HW+1)'(HIST_W) < (HW+1)'(eff_h));

    always_comb begin
        for (int i = 0; i < HIST_W; i++) begin
            x_mask[i] = (in_col_reg > CW'(i));
            y_mask[i] = (in_row_reg > RW'(i));
        end
    end

    assign do_emit = is_pix ? px_emit : frame_rcv_reg;
    assign q_push  = accept && (is_pix || frame_rcv_reg);
    assign q_col   = in_col_reg;

    always_comb begin
        q_cmd.is_pixel = is_pix;
        q_cmd.emit     = do_emit;
        q_cmd.keep     = is_pix && keep;
        q_cmd.last     = out_last;
        q_cmd.bin      = (s_level > thr_reg);
        q_cmd.x_mask   = x_mask;
        q_cmd.y_mask   = y_mask;
    end

    always_comb begin
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        cnt_next       = cnt_reg;
        frame_rcv_next = frame_rcv_reg;
        if (restart) begin
            in_col_next    = '0;
            in_row_next    = '0;
            out_col_next   = '0;
            out_row_next   = '0;
            frame_rcv_next = 1'b0;
        end else if (accept) begin
            if (is_pix) begin
                out_col_next   = oc_base;
                out_row_next   = or_base;
                frame_rcv_next = 1'b0;
                cnt_next       = px_emit ? cnt_cur : cnt_cur + CNTW'(1);
                if (in_col_wrap) begin
                    in_col_next = '0;
                    if (in_row_wrap) begin
                        in_row_next    = '0;
                        frame_rcv_next = 1'b1;
                    end else begin
                        in_row_next = in_row_reg + RW'(1);
                    end
                end else begin
                    in_col_next = in_col_reg + CW'(1);
                end
            end
            if (do_emit) begin
                if (out_last) begin
                    out_col_next   = '0;
                    out_row_next   = '0;
                    frame_rcv_next = 1'b0;
                end else if (out_eol) begin
                    out_col_next = '0;
                    out_row_next = or_base + RW'(1);
                end else begin
                    out_col_next = oc_base + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg       <= clsd_pkg::THRESHOLD_RST;
            fw_reg        <= clsd_pkg::FRAME_DIM_RST;
            fh_reg        <= clsd_pkg::FRAME_DIM_RST;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            cnt_reg       <= '0;
            frame_rcv_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    clsd_pkg::CFG_THRESHOLD:    thr_reg <= cfg_wdata[7:0];
                    clsd_pkg::CFG_FRAME_WIDTH:  fw_reg  <= cfg_wdata;
                    clsd_pkg::CFG_FRAME_HEIGHT: fh_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            cnt_reg       <= cnt_next;
            frame_rcv_reg <= frame_rcv_next;
        end
    end

    // A completed input frame always leaves the input position at the origin
    a_rcv_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_rcv_reg |-> (in_col_reg == '0 && in_row_reg == '0))
        else $error("frame received but input position not at origin");

    // Queue is never pushed while full
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("push into full queue");

    // Output position stays inside the frame
    a_out_col: assert property (@(posedge aclk) disable iff (!aresetn)
        WW'(out_col_reg) < eff_w)
        else $error("output column out of frame");

endmodule

FILE: hdl/clsd_back.sv
// clsd_back: line-store read/modify/write, dilation and erosion, output register.
// Depends on clsd_pkg and clsd_ram.
module clsd_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  clsd_pkg::cmd_t                q_cmd,
    input  logic [$clog2(MAX_WIDTH)-1:0]  q_col,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_closed_pixel,
    output logic                          m_last_in_frame
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int HIST_W = clsd_pkg::HIST_W;

    logic [HIST_W-1:0] bin_rd, dil_rd, bin_hist, dil_hist, bin_new, dil_new;
    logic [HIST_W-1:0] fwd_bin_reg, fwd_dil_reg, wc0_reg, wc1_reg, wc0_new, wc1_new;
    logic              b_valid_reg, fwd_reg, fwd_next;
    clsd_pkg::cmd_t    b_cmd_reg;
    logic [CW-1:0]     b_col_reg;
    logic              m_valid_reg, m_last_reg;
    logic [7:0]        m_pix_reg;
    logic              b_adv, st_we;
    logic              col_or, dil, ver, hv;

    clsd_ram #(.WIDTH(HIST_W), .DEPTH(MAX_WIDTH)) u_bin_ram (
        .aclk    (aclk),
        .wr_en   (st_we),
        .wr_addr (b_col_reg),
        .wr_data (bin_new),
        .rd_en   (q_pop),
        .rd_addr (q_col),
        .rd_data (bin_rd)
    );

    clsd_ram #(.WIDTH(HIST_W), .DEPTH(MAX_WIDTH)) u_dil_ram (
        .aclk    (aclk),
        .wr_en   (st_we),
        .wr_addr (b_col_reg),
        .wr_data (dil_new),
        .rd_en   (q_pop),
        .rd_addr (q_col),
        .rd_data (dil_rd)
    );

    // Same column written in the cycle of the read (one-pixel lines): bypass
    assign bin_hist = fwd_reg ? fwd_bin_reg : bin_rd;
    assign dil_hist = fwd_reg ? fwd_dil_reg : dil_rd;

    // Dilation: vertical OR, then horizontal OR
    assign col_or  = b_cmd_reg.bin || ((bin_hist & b_cmd_reg.y_mask) != '0);
    assign bin_new = HIST_W'({bin_hist, b_cmd_reg.bin});
    assign dil     = col_or || ((wc0_reg & b_cmd_reg.x_mask) != '0);
    assign wc0_new = HIST_W'({wc0_reg, col_or});

    // Erosion: vertical AND, then horizontal AND
    assign ver     = dil && (&dil_hist) && b_cmd_reg.y_mask[HIST_W-1];
    assign dil_new = HIST_W'({dil_hist, dil});
    assign hv      = ver && (&wc1_reg) && b_cmd_reg.x_mask[HIST_W-1];
    assign wc1_new = HIST_W'({wc1_reg, ver});

    assign b_adv    = b_valid_reg && (!b_cmd_reg.emit || !m_valid_reg || m_ready);
    assign q_pop    = q_valid && (!b_valid_reg || b_adv);
    assign st_we    = b_adv && b_cmd_reg.is_pixel;
    assign fwd_next = st_we && (q_col == b_col_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            wc0_reg     <= '0;
            wc1_reg     <= '0;
        end else begin
            if (q_pop) begin
                b_valid_reg <= 1'b1;
                fwd_reg     <= fwd_next;
            end else if (b_adv) begin
                b_valid_reg <= 1'b0;
            end
            if (st_we) begin
                wc0_reg <= wc0_new;
                wc1_reg <= wc1_new;
            end
            if (b_adv && b_cmd_reg.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            b_cmd_reg   <= q_cmd;
            b_col_reg   <= q_col;
            fwd_bin_reg <= bin_new;
            fwd_dil_reg <= dil_new;
        end
        if (b_adv && b_cmd_reg.emit) begin
            m_pix_reg  <= (b_cmd_reg.keep && hv) ? clsd_pkg::PIX_SET : clsd_pkg::PIX_CLR;
            m_last_reg <= b_cmd_reg.last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_closed_pixel  = m_pix_reg;
    assign m_last_in_frame = m_last_reg;

    // A held stage never takes a new request
    a_no_pop_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && !b_adv) |-> !q_pop)
        else $error("pop while stage held");

    // An emitting request never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !(b_adv && b_cmd_reg.emit))
        else $error("result register overwritten");

    // Drain requests always carry a clear result
    a_drain_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && !b_cmd_reg.is_pixel) |-> (!b_cmd_reg.keep && b_cmd_reg.emit))
        else $error("drain request misclassified");

endmodule

FILE: hdl/binary_closing_3x3_stream.sv
// binary_closing_3x3_stream: top level of the streaming 3x3 binary closing block.
// Depends on clsd_pkg, clsd_front, clsd_fifo, clsd_back (and clsd_ram below it).
//
//   channel   dir   handshake               payload
//   s_*       in    s_valid / s_ready       s_kind, s_level
//   m_*       out   m_valid / m_ready       m_closed_pixel, m_last_in_frame
//   cfg_*     in    cfg_wr_en (no wait)     cfg_index, cfg_wdata
//
// One request per clock while the output is not stalled; results pass the queue,
// back stage and output register, behind a fill lag of 2*(width+1) pixels.
// The rate is set by the two line RAMs, each doing one read and one write a cycle.
// Synchronous active-low reset clears control state; line RAMs keep no reset.
// Input and output stall independently: a four-entry queue and the output
// register sit between the front classifier and the RAM/window back end.
module binary_closing_3x3_stream #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             cfg_wr_en,
    input  logic [clsd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [clsd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input requests
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_kind,
    input  logic [7:0]                       s_level,
    // results
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [7:0]                       m_closed_pixel,
    output logic                             m_last_in_frame
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int CMD_W = $bits(clsd_pkg::cmd_t);
    localparam int QW    = CMD_W + CW;

    // front -> queue
    clsd_pkg::cmd_t  fr_cmd;
    logic [CW-1:0]   fr_col;
    logic            fr_push, q_full;

    // queue -> back
    logic [QW-1:0]   q_head;
    logic            q_not_empty, q_pop;
    clsd_pkg::cmd_t  bk_cmd;
    logic [CW-1:0]   bk_col;

    // Front: config registers, raster counters, result bookkeeping.
    // Every accepted pixel and every drain that still owes a result is queued.
    clsd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_kind    (s_kind),
        .s_level   (s_level),
        .q_push    (fr_push),
        .q_cmd     (fr_cmd),
        .q_col     (fr_col),
        .q_full    (q_full)
    );

    // Decoupling queue: command flags on top, column address below
    clsd_fifo #(
        .WIDTH (QW),
        .DEPTH (clsd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fr_push),
        .push_data ({fr_cmd, fr_col}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_head),
        .not_empty (q_not_empty)
    );

    assign bk_cmd = clsd_pkg::cmd_t'(q_head[QW-1:CW]);
    assign bk_col = q_head[CW-1:0];

    // Back: line-store update, 3x3 dilation then erosion, result register
    clsd_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_not_empty),
        .q_cmd           (bk_cmd),
        .q_col           (bk_col),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_closed_pixel  (m_closed_pixel),
        .m_last_in_frame (m_last_in_frame)
    );

endmodule

FILE: bench/binary_closing_3x3_stream_tb.sv
// binary_closing_3x3_stream_tb: self-checking bench for the streaming 3x3 binary closing block.
// Depends on clsd_pkg and binary_closing_3x3_stream; a cycle-free closing predictor
// checks every result pixel against the raster-order expectation.
`timescale 1ns / 1ps

module binary_closing_3x3_stream_tb;

    localparam int FRAME_MAX     = 1024;   // DUT default MAX_WIDTH / MAX_HEIGHT
    localparam int SETTLE_CYCLES = 24;     // queue + back end drain before a register write
    localparam int STUCK_LIMIT   = 4000;   // cycles with work pending but no handshake

    localparam int HIST_W     = clsd_pkg::HIST_W;
    localparam int CFG_IDX_W  = clsd_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = clsd_pkg::CFG_DATA_W;

    // request kinds on the s_ channel
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // write masks, one bit per register index
    localparam logic [3:0] WR_THR    = 4'b1 << clsd_pkg::CFG_THRESHOLD;
    localparam logic [3:0] WR_WIDTH  = 4'b1 << clsd_pkg::CFG_FRAME_WIDTH;
    localparam logic [3:0] WR_HEIGHT = 4'b1 << clsd_pkg::CFG_FRAME_HEIGHT;
    localparam logic [3:0] WR_SPARE  = 4'b1 << CFG_SPARE;
    localparam logic [3:0] WR_ALL    = WR_THR | WR_WIDTH | WR_HEIGHT;

    typedef struct packed {
        logic       kind;
        logic [7:0] level;
    } gray_req_t;

    typedef struct packed {
        logic [7:0] pixel;
        logic       last;
    } closed_px_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic                  s_kind    = KIND_PIXEL;
    logic [7:0]            s_level   = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [7:0]            m_closed_pixel;
    logic                  m_last_in_frame;

    binary_closing_3x3_stream DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_level         (s_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_closed_pixel  (m_closed_pixel),
        .m_last_in_frame (m_last_in_frame)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Stimulus backlog, expected results, counters
    // ------------------------------------------------------------------
    gray_req_t  req_backlog[$];
    closed_px_t closed_due[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int errors         = 0;
    int reqs_taken     = 0;
    int pixels_checked = 0;
    int frames_closed  = 0;
    int reg_writes     = 0;
    int stuck_cycles   = 0;

    // register values the stimulus side last wrote (drives frame generation)
    logic [7:0]            plan_thr = clsd_pkg::THRESHOLD_RST;
    logic [CFG_DATA_W-1:0] plan_w   = clsd_pkg::FRAME_DIM_RST;
    logic [CFG_DATA_W-1:0] plan_h   = clsd_pkg::FRAME_DIM_RST;

    // ------------------------------------------------------------------
    // Closing predictor state: registers, two per-column line histories,
    // the two horizontal window histories and the raster positions.
    // ------------------------------------------------------------------
    logic [7:0]            thr_reg;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic [HIST_W-1:0]     bin_hist [FRAME_MAX];
    logic [HIST_W-1:0]     dil_hist [FRAME_MAX];
    logic [HIST_W-1:0]     or_cols;    // column ORs feeding dilation
    logic [HIST_W-1:0]     and_cols;   // column ANDs feeding erosion
    int unsigned           in_col, in_row, out_col, out_row;
    logic                  frame_pending;  // whole frame taken in, tail still owed

    // sizes are clamped to 1..FRAME_MAX
    function automatic int unsigned clamp_dim(input logic [CFG_DATA_W-1:0] v);
        if (v < 1) return 1;
        if (v > FRAME_MAX) return FRAME_MAX;
        return 32'(v);
    endfunction

    function automatic void rewind_frame();
        in_col        = 0;
        in_row        = 0;
        out_col       = 0;
        out_row       = 0;
        frame_pending = 1'b0;
        or_cols       = '0;
        and_cols      = '0;
    endfunction

    // queue one result pixel and advance the output raster position
    function automatic void emit_closed(input logic set);
        int unsigned w, h;
        logic        last;
        w    = clamp_dim(width_reg);
        h    = clamp_dim(height_reg);
        last = (out_col + 1 == w) && (out_row + 1 == h);
        closed_due.push_back('{set ? clsd_pkg::PIX_SET : clsd_pkg::PIX_CLR, last});
        if (last) begin
            out_col       = 0;
            out_row       = 0;
            frame_pending = 1'b0;
        end else if (out_col + 1 >= w) begin
            out_col = 0;
            out_row++;
        end else begin
            out_col++;
        end
    endfunction

    // one accepted request through threshold, dilation and erosion
    function automatic void morph_close_step(input logic kind, input logic [7:0] level);
        int unsigned       w, h, x, y, lag;
        logic [HIST_W-1:0] rmask, cmask, hist, dh;
        logic              b, col_or, d, v, hv, keep;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        if (kind == KIND_DRAIN) begin
            // drain only pays out a tail that is owed; otherwise ignored
            if (frame_pending) emit_closed(1'b0);
            return;
        end
        // a pixel during the tail throws the tail away and opens a new frame
        if (frame_pending) begin
            out_col       = 0;
            out_row       = 0;
            frame_pending = 1'b0;
        end
        x = (in_col >= w) ? w - 1 : in_col;
        y = (in_row >= h) ? h - 1 : in_row;
        b = level > thr_reg;

        // dilation: lines above (only those of this frame), then columns to the left
        rmask       = (y >= HIST_W) ? {HIST_W{1'b1}} : HIST_W'((1 << y) - 1);
        hist        = bin_hist[x];
        col_or      = b || ((hist & rmask) != '0);
        bin_hist[x] = HIST_W'({hist, b});
        cmask       = (x >= HIST_W) ? {HIST_W{1'b1}} : HIST_W'((1 << x) - 1);
        d           = col_or || ((or_cols & cmask) != '0);
        or_cols     = HIST_W'({or_cols, col_or});

        // erosion: full vertical run, then full horizontal run
        dh          = dil_hist[x];
        v           = d && (dh == {HIST_W{1'b1}}) && (y >= HIST_W);
        dil_hist[x] = HIST_W'({dh, d});
        hv          = v && (and_cols == {HIST_W{1'b1}}) && (x >= HIST_W);
        and_cols    = HIST_W'({and_cols, v});

        if (x + 1 >= w) begin
            in_col = 0;
            if (y + 1 >= h) begin
                in_row        = 0;
                frame_pending = 1'b1;
            end else begin
                in_row = y + 1;
            end
        end else begin
            in_col = x + 1;
            in_row = y;
        end

        // nothing comes out until the two-line-plus-two fill is done
        lag = HIST_W * (w + 1);
        if (y * w + x < lag) return;
        keep = (out_col + HIST_W < w) && (out_row + HIST_W < h);
        emit_closed(keep && hv);
    endfunction

    task automatic flag_mismatch(input string msg);
        errors++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Driver: request channel. Valid is held with its payload until taken.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_kind  <= req_backlog[0].kind;
                s_level <= req_backlog[0].level;
                void'(req_backlog.pop_front());
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks results, follows register writes, predicts from
    // accepted requests, and runs the stall watchdog. Results are checked
    // before the same edge's request is predicted, so a stray result is
    // never matched against an expectation created in the same cycle.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        closed_px_t want;
        if (!aresetn) begin
            thr_reg    = clsd_pkg::THRESHOLD_RST;
            width_reg  = clsd_pkg::FRAME_DIM_RST;
            height_reg = clsd_pkg::FRAME_DIM_RST;
            for (int k = 0; k < FRAME_MAX; k++) begin
                bin_hist[k] = '0;
                dil_hist[k] = '0;
            end
            rewind_frame();
        end else begin
            if (m_valid && m_ready) begin
                if (closed_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result pixel=%0d last=%0b",
                                            m_closed_pixel, m_last_in_frame));
                end else begin
                    want = closed_due.pop_front();
                    pixels_checked++;
                    if (m_closed_pixel !== want.pixel)
                        flag_mismatch($sformatf("result %0d: closed_pixel %0d, expected %0d",
                                                pixels_checked, m_closed_pixel, want.pixel));
                    if (m_last_in_frame !== want.last)
                        flag_mismatch($sformatf("result %0d: last_in_frame %0b, expected %0b",
                                                pixels_checked, m_last_in_frame, want.last));
                    if (want.last) frames_closed++;
                end
            end

            if (cfg_wr_en) begin
                reg_writes++;
                case (cfg_index)
                    clsd_pkg::CFG_THRESHOLD: begin
                        thr_reg = cfg_wdata[7:0];
                    end
                    clsd_pkg::CFG_FRAME_WIDTH: begin
                        width_reg = cfg_wdata;
                        rewind_frame();
                    end
                    clsd_pkg::CFG_FRAME_HEIGHT: begin
                        height_reg = cfg_wdata;
                        rewind_frame();
                    end
                    default: ;
                endcase
            end

            if (s_valid && s_ready) begin
                reqs_taken++;
                morph_close_step(s_kind, s_level);
            end

            // watchdog only runs while something is still owed
            if ((s_valid && s_ready) || (m_valid && m_ready) ||
                (req_backlog.size() == 0 && !s_valid && closed_due.size() == 0)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
                if (stuck_cycles >= STUCK_LIMIT) begin
                    $display("watchdog: no handshake for %0d cycles, %0d results owed",
                             STUCK_LIMIT, closed_due.size());
                    $display("binary_closing_3x3_stream_tb: FAIL");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_req(input logic kind, input logic [7:0] level);
        req_backlog.push_back('{kind, level});
    endfunction

    // block is idle: backlog sent, every result back, pipeline given time
    task automatic settle();
        while (req_backlog.size() != 0 || s_valid || closed_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // back-to-back register writes, one per edge, strobe dropped afterward
    task automatic write_regs(input logic [3:0] which, input logic [7:0] thr,
                              input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        if (which & WR_THR) begin
            @(posedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_index <= clsd_pkg::CFG_THRESHOLD;
            cfg_wdata <= CFG_DATA_W'(thr);
            plan_thr  = thr;
        end
        if (which & WR_WIDTH) begin
            @(posedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_index <= clsd_pkg::CFG_FRAME_WIDTH;
            cfg_wdata <= w;
            plan_w    = w;
        end
        if (which & WR_HEIGHT) begin
            @(posedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_index <= clsd_pkg::CFG_FRAME_HEIGHT;
            cfg_wdata <= h;
            plan_h    = h;
        end
        if (which & WR_SPARE) begin
            @(posedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_SPARE;
            cfg_wdata <= CFG_DATA_W'($urandom);
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly whole frames followed by exactly the owed drain; now and then the
    // drain is cut short (next pixel drops the tail), padded with idle drains,
    // or sprinkled with stray drains mid-frame. A frame larger than the budget
    // is sent partially and abandoned by the next size write.
    task automatic queue_frames(input int budget);
        int unsigned w, h, area, lag, owed, n_px, n_drain, dens;
        logic [7:0]  lvl;
        w    = clamp_dim(plan_w);
        h    = clamp_dim(plan_h);
        area = w * h;
        lag  = HIST_W * (w + 1);
        owed = (lag < area) ? lag : area;
        while (budget > 0) begin
            dens = $urandom_range(100);  // per-frame share of set pixels
            n_px = (area < budget) ? area : budget;
            for (int unsigned k = 0; k < n_px; k++) begin
                if ($urandom_range(49) == 0) queue_req(KIND_DRAIN, 8'($urandom));
                if (plan_thr == 8'hFF || $urandom_range(99) >= dens)
                    lvl = 8'($urandom_range(int'(plan_thr), 0));
                else
                    lvl = 8'($urandom_range(255, int'(plan_thr) + 1));
                queue_req(KIND_PIXEL, lvl);
            end
            budget -= n_px;
            if (n_px == area) begin
                case ($urandom_range(7))
                    0:       n_drain = $urandom_range(owed - 1);
                    1:       n_drain = owed + $urandom_range(4, 1);
                    default: n_drain = owed;
                endcase
                repeat (n_drain) queue_req(KIND_DRAIN, 8'($urandom));
                budget -= n_drain;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0]            frame_a [9] = '{8'd255, 8'd0,   8'd129,
                                               8'd128, 8'd255, 8'd0,
                                               8'd255, 8'd127, 8'd255};
        logic [7:0]            frame_b [9] = '{8'd0, 8'd0,   8'd0,
                                               8'd0, 8'd255, 8'd0,
                                               8'd0, 8'd0,   8'd1};
        logic [3:0]            mask;
        logic [7:0]            thr;
        logic [CFG_DATA_W-1:0] w, h;
        int                    budget;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: 3x3 frames at the reset threshold, no idling
        write_regs(WR_ALL, clsd_pkg::THRESHOLD_RST, 11'd3, 11'd3);
        queue_req(KIND_DRAIN, 8'hFF);                 // drain with nothing owed
        foreach (frame_a[k]) queue_req(KIND_PIXEL, frame_a[k]);
        repeat (3) queue_req(KIND_DRAIN, 8'h00);      // partial tail ...
        foreach (frame_b[k]) queue_req(KIND_PIXEL, frame_b[k]);  // ... dropped by a pixel
        repeat (8) queue_req(KIND_DRAIN, 8'h5A);

        // random segments, each with its own register setting and idling mix
        for (int seg = 0; seg < 16; seg++) begin
            settle();
            mask   = WR_ALL;
            thr    = plan_thr;
            w      = plan_w;
            h      = plan_h;
            budget = 40;
            case (seg)
                0:  begin thr = 8'd0;   w = 11'd3; h = 11'd3; end
                1:  begin thr = 8'd255; w = 11'd6; h = 11'd5; budget = 60; end
                2:  begin  // threshold only, mid-stream position kept
                    mask = WR_THR | WR_SPARE;
                    thr  = 8'($urandom_range(254, 1));
                end
                3:  begin mask = WR_WIDTH | WR_HEIGHT; w = 11'd4; h = 11'd2047; end
                4:  begin w = 11'd1; h = 11'd5; budget = 30; end
                5:  begin w = 11'd2; h = 11'd2; budget = 30; end
                6:  begin w = 11'd0; h = 11'd0; budget = 20; end
                7:  begin w = 11'd3; h = 11'd1; budget = 30; end
                8:  begin w = 11'd2047; h = 11'd3; end  // oversize width, clamped
                9:  begin w = 11'd1024; h = 11'd1024; budget = 30; end
                10: begin thr = clsd_pkg::THRESHOLD_RST; w = 11'd7; h = 11'd6; budget = 100; end
                default: begin
                    thr    = 8'($urandom);
                    w      = 11'($urandom_range(12, 3));
                    h      = 11'($urandom_range(10, 3));
                    budget = 40;
                end
            endcase
            case (seg % 4)
                0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct <= 73; recv_stall_pct <= 0;  end
                2: begin send_idle_pct <= 0;  recv_stall_pct <= 73; end
                default: begin send_idle_pct <= 19; recv_stall_pct <= 19; end
            endcase
            write_regs(mask, thr, w, h);
            queue_frames(budget);
        end

        settle();
        $display("covered %0d requests and %0d checked result pixels, %0d frames closed",
                 reqs_taken, pixels_checked, frames_closed);
        $display("%0d register writes: sizes 0 to 2047, thresholds 0 to 255, idling up to 73%%",
                 reg_writes);
        if (errors == 0) begin
            $display("binary_closing_3x3_stream_tb: PASS");
        end else begin
            $display("binary_closing_3x3_stream_tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/clsd_pkg.sv
hdl/clsd_ram.sv
hdl/clsd_fifo.sv
hdl/clsd_front.sv
hdl/clsd_back.sv
hdl/binary_closing_3x3_stream.sv
bench/binary_closing_3x3_stream_tb.sv
